// File: src/kfc_pkg.sv
package kfc_pkg;

  localparam int unsigned MAX_KEY_BYTES = 32;
  localparam int unsigned ADDR_W        = $clog2(MAX_KEY_BYTES);
  localparam int unsigned LEN_W         = 6;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned TOTAL_W       = 16;

  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_COMPRESS_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SHARED_PREFIX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_KEY_LENGTH    = 2'd2;

  localparam logic             RST_COMPRESS_ENABLE   = 1'b1;
  localparam logic [LEN_W-1:0] RST_MIN_SHARED_PREFIX = 6'd4;
  localparam logic [LEN_W-1:0] RST_MIN_KEY_LENGTH    = 6'd8;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

endpackage

// File: src/kfc_if.sv
interface kfc_in_if;
  logic                        valid;
  logic                        ready;
  logic [kfc_pkg::BYTE_W-1:0]  key_byte;
  logic                        page_start;
  logic                        key_end;

  modport source (output valid, output key_byte, output page_start, output key_end,
                  input ready);
  modport sink (input valid, input key_byte, input page_start, input key_end,
                output ready);
endinterface

interface kfc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [kfc_pkg::LEN_W-1:0]   omit_len;
  logic [kfc_pkg::LEN_W-1:0]   suffix_len;
  logic [kfc_pkg::BYTE_W-1:0]  data_byte;
  logic [kfc_pkg::TOTAL_W-1:0] prefix_total;
  logic [kfc_pkg::LEN_W-1:0]   least_prefix;
  logic                        key_overflow;
  logic                        last_result;

  modport source (output valid, output kind, output omit_len, output suffix_len,
                  output data_byte, output prefix_total, output least_prefix,
                  output key_overflow, output last_result, input ready);
  modport sink (input valid, input kind, input omit_len, input suffix_len,
                input data_byte, input prefix_total, input least_prefix,
                input key_overflow, input last_result, output ready);
endinterface

// File: src/key_front_coding_encoder.sv
// Front-coding encoder for a sorted key stream, one key byte per input transfer. Each byte is
// compared with the same position of the previous key, held in a key store of
// MAX_KEY_BYTES bytes, and then overwrites it. At the byte marked key_end the block emits a
// header (kind 0) and then one data result per suffix byte. An input byte passes through S_IN
// (accept and store read) and then S_CMP (compare and write). At the end of a key the block
// goes through S_EVAL for the prefix decision and statistics and S_HDR for the header, then
// through S_RD and S_OUT for each suffix byte, since each suffix byte is read back through the
// registered store port; S_HDR and S_OUT wait while the output is stalled. Bytes past
// the store size are dropped and the key is flagged with key_overflow. Configuration writes
// are taken at any edge with cfg_we_i high but are meant for an idle block.
module key_front_coding_encoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kfc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [kfc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  kfc_in_if.sink                            in_i,
  kfc_out_if.source                         out_o
);

  localparam int unsigned LenW   = kfc_pkg::LEN_W;
  localparam int unsigned AddrW  = kfc_pkg::ADDR_W;
  localparam int unsigned ByteW  = kfc_pkg::BYTE_W;
  localparam int unsigned TotalW = kfc_pkg::TOTAL_W;
  localparam logic [LenW-1:0]   MaxLen   = LenW'(kfc_pkg::MAX_KEY_BYTES);
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  typedef enum logic [2:0] {
    S_IN,
    S_CMP,
    S_EVAL,
    S_HDR,
    S_RD,
    S_OUT
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic            comp_en_q;
  logic [LenW-1:0] min_sp_q;
  logic [LenW-1:0] min_kl_q;

  // Key state.
  logic [ByteW-1:0]  byte_q;
  logic              end_q;
  logic [LenW-1:0]   prev_len_q;
  logic [LenW-1:0]   cur_len_q;
  logic [LenW-1:0]   match_len_q;
  logic              still_q;
  logic              ovf_q;
  logic [TotalW-1:0] total_q;
  logic [LenW-1:0]   smallest_q;
  logic [LenW-1:0]   pre_q;
  logic [LenW-1:0]   suf_q;
  logic [LenW-1:0]   idx_q;

  // Output register.
  logic              out_valid_q;
  logic              kind_q;
  logic [ByteW-1:0]  data_q;
  logic              last_q;

  logic              in_fire;
  logic              out_free;
  logic              out_load;
  logic              mem_we;
  logic              mem_re;
  logic [AddrW-1:0]  mem_raddr;
  logic [ByteW-1:0]  mem_rdata;
  logic              eligible;
  logic [LenW-1:0]   pre_d;
  logic [TotalW:0]   total_sum;
  logic [LenW-1:0]   idx_inc;

  assign in_i.ready = (state_q == S_IN);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign out_load   = out_free && ((state_q == S_HDR) || (state_q == S_OUT));

  assign mem_we    = (state_q == S_CMP) && (cur_len_q < MaxLen);
  assign mem_re    = in_fire || (state_q == S_RD);
  always_comb begin
    if (state_q == S_RD) begin
      mem_raddr = idx_q[AddrW-1:0];
    end else if (in_i.page_start) begin
      mem_raddr = '0;
    end else begin
      mem_raddr = cur_len_q[AddrW-1:0];
    end
  end

  kfc_key_store #(
    .Depth (kfc_pkg::MAX_KEY_BYTES),
    .Width (ByteW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cur_len_q[AddrW-1:0]),
    .wdata_i (byte_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign eligible  = comp_en_q && (match_len_q >= min_sp_q) && (cur_len_q >= min_kl_q);
  assign pre_d     = eligible ? match_len_q : '0;
  assign total_sum = {1'b0, total_q} + (TotalW + 1)'(pre_d);
  assign idx_inc   = idx_q + LenW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_en_q <= kfc_pkg::RST_COMPRESS_ENABLE;
      min_sp_q  <= kfc_pkg::RST_MIN_SHARED_PREFIX;
      min_kl_q  <= kfc_pkg::RST_MIN_KEY_LENGTH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kfc_pkg::CFG_COMPRESS_ENABLE:   comp_en_q <= cfg_data_i[0];
        kfc_pkg::CFG_MIN_SHARED_PREFIX: min_sp_q  <= cfg_data_i[LenW-1:0];
        kfc_pkg::CFG_MIN_KEY_LENGTH:    min_kl_q  <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IN;
      prev_len_q  <= '0;
      cur_len_q   <= '0;
      match_len_q <= '0;
      still_q     <= 1'b1;
      ovf_q       <= 1'b0;
      total_q     <= '0;
      smallest_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IN: begin
          if (in_fire) begin
            byte_q <= in_i.key_byte;
            end_q  <= in_i.key_end;
            if (in_i.page_start) begin
              // A page start drops any partly received key and the page statistics.
              prev_len_q  <= '0;
              total_q     <= '0;
              smallest_q  <= '0;
              cur_len_q   <= '0;
              match_len_q <= '0;
              still_q     <= 1'b1;
              ovf_q       <= 1'b0;
            end
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (cur_len_q < MaxLen) begin
            if (still_q && (cur_len_q < prev_len_q) && (mem_rdata == byte_q)) begin
              match_len_q <= match_len_q + LenW'(1);
            end else begin
              still_q <= 1'b0;
            end
            cur_len_q <= cur_len_q + LenW'(1);
          end else begin
            ovf_q <= 1'b1;
          end
          state_q <= end_q ? S_EVAL : S_IN;
        end
        S_EVAL: begin
          pre_q <= pre_d;
          suf_q <= cur_len_q - pre_d;
          idx_q <= pre_d;
          if (pre_d != '0) begin
            total_q <= total_sum[TotalW] ? TotalMax : total_sum[TotalW-1:0];
            if ((smallest_q == '0) || (pre_d < smallest_q)) begin
              smallest_q <= pre_d;
            end
          end
          state_q <= S_HDR;
        end
        S_HDR: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            kind_q      <= kfc_pkg::KIND_HEADER;
            data_q      <= '0;
            last_q      <= (suf_q == '0);
            if (suf_q == '0) begin
              prev_len_q  <= cur_len_q;
              cur_len_q   <= '0;
              match_len_q <= '0;
              still_q     <= 1'b1;
              ovf_q       <= 1'b0;
              state_q     <= S_IN;
            end else begin
              state_q <= S_RD;
            end
          end
        end
        S_RD: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            kind_q      <= kfc_pkg::KIND_DATA;
            data_q      <= mem_rdata;
            last_q      <= (idx_inc == cur_len_q);
            idx_q       <= idx_inc;
            if (idx_inc == cur_len_q) begin
              prev_len_q  <= cur_len_q;
              cur_len_q   <= '0;
              match_len_q <= '0;
              still_q     <= 1'b1;
              ovf_q       <= 1'b0;
              state_q     <= S_IN;
            end else begin
              state_q <= S_RD;
            end
          end
        end
        default: begin
          state_q <= S_IN;
        end
      endcase
    end
  end

  // Header-derived fields are taken straight from the key registers, which hold still
  // until the last result of the key has been loaded into the output register.
  logic [LenW-1:0]   pre_out_q;
  logic [LenW-1:0]   suf_out_q;
  logic [TotalW-1:0] total_out_q;
  logic [LenW-1:0]   smallest_out_q;
  logic              ovf_out_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pre_out_q      <= pre_q;
      suf_out_q      <= suf_q;
      total_out_q    <= total_q;
      smallest_out_q <= smallest_q;
      ovf_out_q      <= ovf_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = kind_q;
  assign out_o.omit_len     = pre_out_q;
  assign out_o.suffix_len   = suf_out_q;
  assign out_o.data_byte    = data_q;
  assign out_o.prefix_total = total_out_q;
  assign out_o.least_prefix = smallest_out_q;
  assign out_o.key_overflow = ovf_out_q;
  assign out_o.last_result  = last_q;

endmodule

// File: src/kfc_key_store.sv
module kfc_key_store #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 8,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
